// ===== design/sfv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfv_pkg
// Shared types and constants for the sensor frame validator: frame layout,
// header bytes, verdict codes and the result bundle.
// ----------------------------------------------------------------------------
package sfv_pkg;

    // Verdict codes, in check priority order after VERDICT_VALID
    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_HDR_ERR  = 2'd1,
        VERDICT_STAT_ERR = 2'd2,
        VERDICT_SUM_ERR  = 2'd3
    } verdict_t;

    // Frame kinds as sampled on the first byte
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CONF = 1'b1;

    // Index of the last byte and of the check-word high byte per kind
    localparam logic [3:0] DATA_LAST  = 4'd15;
    localparam logic [3:0] DATA_CHK_HI = 4'd14;
    localparam logic [3:0] CONF_LAST  = 4'd6;
    localparam logic [3:0] CONF_CHK_HI = 4'd5;

    // Status byte positions
    localparam logic [3:0] DATA_STAT_A = 4'd6;
    localparam logic [3:0] DATA_STAT_B = 4'd7;
    localparam logic [3:0] CONF_STAT   = 4'd4;

    // Header length in bytes
    localparam logic [3:0] HDR_LEN = 4'd4;

    // Header words, first byte in the top lane
    localparam logic [31:0] DATA_HDR = 32'hAA07_080A;
    localparam logic [31:0] CONF_HDR = 32'hAA00_5001;

    // One verdict leaving the tracker
    typedef struct packed {
        logic     emit;
        verdict_t verdict;
        logic     config_done;
    } sfv_result_t;

    // Expected header byte for a kind and a header position
    function automatic logic [7:0] hdr_byte(input logic kind, input logic [1:0] pos);
        logic [31:0] word;
        word = (kind == KIND_CONF) ? CONF_HDR : DATA_HDR;
        case (pos)
            2'd0:    hdr_byte = word[31:24];
            2'd1:    hdr_byte = word[23:16];
            2'd2:    hdr_byte = word[15:8];
            default: hdr_byte = word[7:0];
        endcase
    endfunction

endpackage

// ===== design/sfv_if.sv =====
// ----------------------------------------------------------------------------
// sfv_if
// Valid/ready channels of the validator: the byte stream in and the
// verdict stream out.
// ----------------------------------------------------------------------------
interface sfv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       frame_kind;

    modport source (output valid, output rx_byte, output frame_start,
                    output frame_kind, input ready);
    modport sink   (input valid, input rx_byte, input frame_start,
                    input frame_kind, output ready);
endinterface

interface sfv_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       config_done;

    modport source (output valid, output verdict, output config_done, input ready);
    modport sink   (input valid, input verdict, input config_done, output ready);
endinterface

// ===== design/sfv_tracker.sv =====
// ----------------------------------------------------------------------------
// sfv_tracker
// Frame state: byte index, header match, status OR, running sum and check
// byte. Consumes one registered byte per step and forms the verdict on the
// last byte of a frame.
// ----------------------------------------------------------------------------
module sfv_tracker
    import sfv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    input  logic        frame_kind,
    output sfv_result_t result
);

    logic [3:0]  idx_reg, idx_next;
    logic        kind_reg, kind_next;
    logic        in_frame_reg, in_frame_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [7:0]  stat_reg, stat_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  chk_hi_reg, chk_hi_next;
    logic        cfg_seen_reg, cfg_seen_next;

    logic        active;
    logic        kind_eff;
    logic [3:0]  idx_eff;
    logic        hdr_ok_base;
    logic [7:0]  stat_base;
    logic [15:0] sum_base;
    logic [7:0]  chk_hi_base;
    logic [3:0]  last_idx;
    logic [3:0]  chk_idx;
    logic        is_status;
    logic        is_last;
    verdict_t    verdict;

    // Open a fresh frame on a start byte, else continue the open one
    always_comb
    begin
        active      = frame_start || in_frame_reg;
        kind_eff    = frame_start ? frame_kind : kind_reg;
        idx_eff     = frame_start ? '0 : idx_reg;
        hdr_ok_base = frame_start ? 1'b1 : hdr_ok_reg;
        stat_base   = frame_start ? '0 : stat_reg;
        sum_base    = frame_start ? '0 : sum_reg;
        chk_hi_base = frame_start ? '0 : chk_hi_reg;
        last_idx    = (kind_eff == KIND_CONF) ? CONF_LAST : DATA_LAST;
        chk_idx     = (kind_eff == KIND_CONF) ? CONF_CHK_HI : DATA_CHK_HI;
        is_last     = (idx_eff == last_idx);
        if (kind_eff == KIND_CONF)
        begin
            is_status = (idx_eff == CONF_STAT);
        end
        else
        begin
            is_status = (idx_eff == DATA_STAT_A) || (idx_eff == DATA_STAT_B);
        end
    end

    // Update header, status, sum and check byte, then form the verdict
    always_comb
    begin
        hdr_ok_next   = hdr_ok_base;
        stat_next     = stat_base;
        sum_next      = sum_base;
        chk_hi_next   = chk_hi_base;
        idx_next      = idx_reg;
        kind_next     = kind_reg;
        in_frame_next = in_frame_reg;
        cfg_seen_next = cfg_seen_reg;
        verdict       = VERDICT_VALID;

        if (idx_eff < HDR_LEN && rx_byte != hdr_byte(kind_eff, idx_eff[1:0]))
        begin
            hdr_ok_next = 1'b0;
        end
        if (is_status)
        begin
            stat_next = stat_base | rx_byte;
        end
        if (idx_eff < chk_idx)
        begin
            sum_next = sum_base + {8'd0, rx_byte};
        end
        else if (idx_eff == chk_idx)
        begin
            chk_hi_next = rx_byte;
        end

        if (!hdr_ok_next)
        begin
            verdict = VERDICT_HDR_ERR;
        end
        else if (stat_next != '0)
        begin
            verdict = VERDICT_STAT_ERR;
        end
        else if (sum_next != {chk_hi_next, rx_byte})
        begin
            verdict = VERDICT_SUM_ERR;
        end

        if (active)
        begin
            kind_next = kind_eff;
            if (is_last)
            begin
                in_frame_next = 1'b0;
                idx_next      = '0;
                if (verdict == VERDICT_VALID && kind_eff == KIND_CONF)
                begin
                    cfg_seen_next = 1'b1;
                end
            end
            else
            begin
                in_frame_next = 1'b1;
                idx_next      = idx_eff + 4'd1;
            end
        end
        else
        begin
            hdr_ok_next = hdr_ok_reg;
            stat_next   = stat_reg;
            sum_next    = sum_reg;
            chk_hi_next = chk_hi_reg;
        end

        result.emit        = active && is_last;
        result.verdict     = verdict;
        result.config_done = cfg_seen_next;
    end

    // Hold frame state, advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            kind_reg     <= 1'b0;
            in_frame_reg <= 1'b0;
            hdr_ok_reg   <= 1'b1;
            stat_reg     <= '0;
            sum_reg      <= '0;
            chk_hi_reg   <= '0;
            cfg_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            idx_reg      <= idx_next;
            kind_reg     <= kind_next;
            in_frame_reg <= in_frame_next;
            hdr_ok_reg   <= hdr_ok_next;
            stat_reg     <= stat_next;
            sum_reg      <= sum_next;
            chk_hi_reg   <= chk_hi_next;
            cfg_seen_reg <= cfg_seen_next;
        end
    end

endmodule

// ===== design/sfv_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfv_out_stage
// Result register: holds one verdict until the sink takes it and tells the
// upstream stage whether it may advance.
// ----------------------------------------------------------------------------
module sfv_out_stage
    import sfv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  sfv_result_t    result,
    output logic           can_step,
    sfv_verdict_if.source  res
);

    logic       valid_reg;
    verdict_t   verdict_reg;
    logic       cfg_done_reg;

    // Free when empty or when the held verdict leaves this cycle
    assign can_step = !valid_reg || res.ready;

    // Load a new verdict, drop the old one after its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step && result.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
        begin
            verdict_reg  <= result.verdict;
            cfg_done_reg <= result.config_done;
        end
    end

    assign res.valid       = valid_reg;
    assign res.verdict     = verdict_reg;
    assign res.config_done = cfg_done_reg;

endmodule

// ===== design/sensor_frame_validator.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_validator
// Checks serial sensor frames byte by byte and reports one verdict per
// complete frame (header, status, 16-bit additive checksum).
//
//   channel | dir | payload                           | transfer gives
//   rx      | in  | rx_byte, frame_start, frame_kind  | one frame byte
//   res     | out | verdict, config_done              | verdict of one frame
//
// One byte per cycle sustained while res does not stall. A byte waits in the input
// register and is folded into the frame state when it steps; on that same step the frame's
// verdict is loaded into the result register that drives res. rx.ready follows res.ready
// combinationally while a verdict is held and the input register is full.
// Reset clears the frame state; config_done starts low.
// ----------------------------------------------------------------------------
module sensor_frame_validator
    import sfv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfv_byte_if.sink      rx,
    sfv_verdict_if.source res
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;
    logic        s1_kind_reg;
    logic        can_step;
    logic        step;
    sfv_result_t result;

    // Advance the held byte when the result register can take its verdict
    assign step     = s1_valid_reg && can_step;
    assign rx.ready = !s1_valid_reg || can_step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg  <= rx.rx_byte;
            s1_start_reg <= rx.frame_start;
            s1_kind_reg  <= rx.frame_kind;
        end
    end

    sfv_tracker u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .frame_kind  (s1_kind_reg),
        .result      (result)
    );

    sfv_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .result   (result),
        .can_step (can_step),
        .res      (res)
    );

endmodule

// ===== design/sfv_checker.sv =====
// ----------------------------------------------------------------------------
// sfv_checker
// Port-level checks of the validator: verdict hold under stall, sticky
// config_done and its rise only with a valid verdict, and no verdict right after reset.
// ----------------------------------------------------------------------------
module sfv_checker
    import sfv_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_verdict,
    input logic       res_config_done
);

    logic cfg_done_reg;
    logic res_xfer;

    assign res_xfer = res_valid && res_ready;

    // Track config_done of the last delivered verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_done_reg <= 1'b0;
        end
        else if (res_xfer)
        begin
            cfg_done_reg <= res_config_done;
        end
    end

    // A stalled verdict holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_verdict)
                                    && $stable(res_config_done))
        else $error("verdict changed while stalled");

    // config_done never falls once delivered high
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && cfg_done_reg |-> res_config_done)
        else $error("config_done fell");

    // config_done rises only with a valid verdict
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer && res_config_done && !cfg_done_reg |-> res_verdict == VERDICT_VALID)
        else $error("config_done rose on a failing frame");

    // No verdict right after reset
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("verdict valid right after reset");

endmodule

bind sensor_frame_validator sfv_checker u_sfv_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_verdict     (res.verdict),
    .res_config_done (res.config_done)
);

// ===== tb/tb_sensor_frame_validator.sv =====
// ----------------------------------------------------------------------------
// tb_sensor_frame_validator
// Self-checking bench for the sensor frame validator. Frames of both kinds
// are built with a correct header and checksum, then selectively broken:
// header, status and checksum faults, truncated frames, stray bytes and noise.
// A byte-level tracker predicts each verdict at input transfer time. The
// output checker compares every verdict transfer, in order, against it.
// Input gaps come in random bursts. Output stalls follow a pattern of their
// own, and one long output hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_sensor_frame_validator;
    import sfv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF      = 5;
    localparam int          RESET_CYCLES  = 7;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          RANDOM_BYTES  = 360;
    localparam int          MAX_SHOWN     = 10;
    localparam int          SETTLE_CYCLES = 20;
    localparam logic [31:0] HDR_DATA_WORD = 32'hAA07_080A;
    localparam logic [31:0] HDR_CONF_WORD = 32'hAA00_5001;

    typedef enum int {
        FLAW_NONE,
        FLAW_HDR,
        FLAW_STAT,
        FLAW_SUM,
        FLAW_HDR_STAT,
        FLAW_STAT_SUM,
        FLAW_ALL
    } flaw_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_PATTERN,
        RDY_COIN
    } rdy_mode_t;

    typedef struct {
        verdict_t verdict;
        logic     config_done;
    } verdict_exp_t;

    logic clk;
    logic rst_n;

    sfv_byte_if    rx_if();
    sfv_verdict_if res_if();

    sensor_frame_validator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // Frame tracker state, mirrors what the block holds per frame
    logic [3:0]  trk_pos;
    logic        trk_kind;
    logic        trk_open;
    logic        trk_hdr_ok;
    logic [7:0]  trk_stat_or;
    logic [15:0] trk_sum;
    logic [7:0]  trk_chk_hi;
    logic        trk_cfg_done;
    int          folded_bytes;

    verdict_exp_t verdict_q[$];

    int        n_bad;
    int        n_shown;
    int        cycle_cnt;
    int        burst_left;
    bit        idle_on;
    bit        stat_pick;
    int        hold_left;
    rdy_mode_t rdy_mode;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Fold one accepted byte into the tracker; return 1 when it closes a frame
    function automatic bit fold_frame_byte(input logic [7:0] b, input logic st,
                                           input logic kd, output verdict_exp_t r);
        logic [31:0] hdr;
        logic [7:0]  want;
        logic [15:0] word;
        int          last;
        bit          is_stat;
        r.verdict     = VERDICT_VALID;
        r.config_done = 1'b0;
        if (st)
        begin
            trk_pos     = 4'd0;
            trk_kind    = kd;
            trk_open    = 1'b1;
            trk_hdr_ok  = 1'b1;
            trk_stat_or = 8'h00;
            trk_sum     = 16'h0000;
            trk_chk_hi  = 8'h00;
        end
        else if (!trk_open)
        begin
            return 1'b0;
        end
        folded_bytes++;
        last = (trk_kind == KIND_CONF) ? 6 : 15;

        // Header bytes
        if (trk_pos < 4)
        begin
            hdr  = (trk_kind == KIND_CONF) ? HDR_CONF_WORD : HDR_DATA_WORD;
            want = hdr[31 - 8 * trk_pos[1:0] -: 8];
            if (b != want)
                trk_hdr_ok = 1'b0;
        end

        // Status bytes
        if (trk_kind == KIND_CONF)
            is_stat = (trk_pos == 4);
        else
            is_stat = (trk_pos == 6 || trk_pos == 7);
        if (is_stat)
            trk_stat_or = trk_stat_or | b;

        // Running sum, then the check word high byte
        if (trk_pos < last - 1)
            trk_sum = trk_sum + 16'(b);
        else if (trk_pos == last - 1)
            trk_chk_hi = b;

        // Last byte: rank the faults
        if (trk_pos == last)
        begin
            word = {trk_chk_hi, b};
            if (!trk_hdr_ok)
                r.verdict = VERDICT_HDR_ERR;
            else if (trk_stat_or != 8'h00)
                r.verdict = VERDICT_STAT_ERR;
            else if (trk_sum != word)
                r.verdict = VERDICT_SUM_ERR;
            else
                r.verdict = VERDICT_VALID;
            if (r.verdict == VERDICT_VALID && trk_kind == KIND_CONF)
                trk_cfg_done = 1'b1;
            r.config_done = trk_cfg_done;
            trk_open      = 1'b0;
            trk_pos       = 4'd0;
            return 1'b1;
        end
        trk_pos = trk_pos + 4'd1;
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string msg);
        n_bad++;
        if (n_shown < MAX_SHOWN)
        begin
            n_shown++;
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    // Predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        verdict_exp_t e;
        verdict_exp_t got;
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            if (fold_frame_byte(rx_if.rx_byte, rx_if.frame_start, rx_if.frame_kind, e))
                verdict_q.push_back(e);
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.verdict     = verdict_t'(res_if.verdict);
            got.config_done = res_if.config_done;
            if (verdict_q.size() == 0)
            begin
                note_mismatch($sformatf("unexpected verdict %s config_done %0b",
                                        got.verdict.name(), got.config_done));
            end
            else
            begin
                e = verdict_q.pop_front();
                if (got.verdict !== e.verdict || got.config_done !== e.config_done)
                    note_mismatch($sformatf("expected %s/%0b got %s/%0b",
                                            e.verdict.name(), e.config_done,
                                            got.verdict.name(), got.config_done));
            end
        end
    end

    // Output side: long hold-off first, else the current stall pattern
    initial
    begin
        logic [7:0] rdy_pat;
        int         pat_pos;
        rdy_pat         = 8'hFF;
        pat_pos         = 0;
        res_if.ready    = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                case (rdy_mode)
                    RDY_ALWAYS:  res_if.ready <= 1'b1;
                    RDY_COIN:    res_if.ready <= 1'($urandom);
                    default:     res_if.ready <= rdy_pat[pat_pos];
                endcase
                pat_pos++;
                if (pat_pos == 8)
                begin
                    pat_pos = 0;
                    rdy_pat = 8'($urandom_range(1, 255));
                end
            end
        end
    end

    // Cycle limit
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("** sensor_frame_validator: FAILED **");
        $finish;
    end

    // Offer one byte and hold it until its transfer; insert burst gaps
    task automatic send_byte(input logic [7:0] b, input logic st, input logic kd);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            rx_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        rx_if.valid       <= 1'b1;
        rx_if.rx_byte     <= b;
        rx_if.frame_start <= st;
        rx_if.frame_kind  <= kd;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and wait until every predicted verdict has been seen
    task automatic wait_drained();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    // Build a frame of one kind with the given faults, send its first n bytes
    task automatic send_frame(input logic kd, input flaw_t flaw, input fill_t fill,
                              input int n);
        logic [7:0]  fb[16];
        logic [31:0] hdr;
        logic [15:0] sum;
        int          len;
        int          sp;
        len = (kd == KIND_CONF) ? 7 : 16;
        hdr = (kd == KIND_CONF) ? HDR_CONF_WORD : HDR_DATA_WORD;
        for (int i = 0; i < 16; i++)
        begin
            case (fill)
                FILL_ZERO: fb[i] = 8'h00;
                FILL_ONES: fb[i] = 8'hFF;
                default:   fb[i] = 8'($urandom);
            endcase
        end
        for (int i = 0; i < 4; i++)
            fb[i] = hdr[31 - 8 * i -: 8];
        if (kd == KIND_CONF)
        begin
            fb[4] = 8'h00;
            sp    = 4;
        end
        else
        begin
            fb[6]     = 8'h00;
            fb[7]     = 8'h00;
            sp        = stat_pick ? 7 : 6;
            stat_pick = ~stat_pick;
        end

        // Break header and status before the checksum is formed
        if (flaw inside {FLAW_HDR, FLAW_HDR_STAT, FLAW_ALL})
        begin
            sp = $urandom_range(0, 3);
            fb[sp] = fb[sp] ^ (8'h01 << $urandom_range(0, 7));
            sp = (kd == KIND_CONF) ? 4 : 6 + int'($urandom_range(0, 1));
        end
        if (flaw inside {FLAW_STAT, FLAW_HDR_STAT, FLAW_STAT_SUM, FLAW_ALL})
            fb[sp] = 8'($urandom_range(1, 255));

        // Big-endian check word over all but the last two bytes
        sum = 16'h0000;
        for (int i = 0; i < len - 2; i++)
            sum = sum + 16'(fb[i]);
        if (flaw inside {FLAW_SUM, FLAW_STAT_SUM, FLAW_ALL})
            sum = sum + 16'($urandom_range(1, 65535));
        fb[len - 2] = sum[15:8];
        fb[len - 1] = sum[7:0];

        // frame_kind is a don't-care after the first byte
        for (int i = 0; i < n && i < len; i++)
            send_byte(fb[i], i == 0, (i == 0) ? kd : 1'($urandom));
    endtask

    function automatic flaw_t pick_flaw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return FLAW_NONE;
        else if (r < 67)
            return FLAW_HDR;
        else if (r < 79)
            return FLAW_STAT;
        else if (r < 91)
            return FLAW_SUM;
        else if (r < 94)
            return FLAW_HDR_STAT;
        else if (r < 97)
            return FLAW_STAT_SUM;
        return FLAW_ALL;
    endfunction

    // Each fault kind, priorities, restarts and ignored bytes
    task automatic test_directed_frames();
        idle_on  = 1'b0;
        rdy_mode = RDY_ALWAYS;

        // Bytes with no open frame
        send_byte(8'h00, 1'b0, KIND_DATA);
        send_byte(8'hFF, 1'b0, KIND_CONF);

        send_frame(KIND_DATA, FLAW_NONE, FILL_ZERO, 16);
        send_frame(KIND_CONF, FLAW_HDR, FILL_RANDOM, 7);
        send_frame(KIND_CONF, FLAW_STAT, FILL_RANDOM, 7);
        send_frame(KIND_CONF, FLAW_SUM, FILL_RANDOM, 7);
        send_frame(KIND_CONF, FLAW_NONE, FILL_ONES, 7);

        idle_on  = 1'b1;
        rdy_mode = RDY_PATTERN;
        send_frame(KIND_DATA, FLAW_NONE, FILL_ONES, 16);
        send_frame(KIND_DATA, FLAW_HDR, FILL_ONES, 16);
        send_frame(KIND_DATA, FLAW_STAT, FILL_RANDOM, 16);
        send_frame(KIND_DATA, FLAW_STAT, FILL_RANDOM, 16);
        send_frame(KIND_DATA, FLAW_SUM, FILL_RANDOM, 16);
        send_frame(KIND_DATA, FLAW_HDR_STAT, FILL_RANDOM, 16);
        send_frame(KIND_DATA, FLAW_STAT_SUM, FILL_RANDOM, 16);
        send_frame(KIND_DATA, FLAW_ALL, FILL_RANDOM, 16);

        // Restart mid-frame, also on the very first byte
        send_frame(KIND_DATA, FLAW_NONE, FILL_RANDOM, 9);
        send_frame(KIND_CONF, FLAW_NONE, FILL_RANDOM, 1);
        send_frame(KIND_CONF, FLAW_NONE, FILL_RANDOM, 7);

        // Bytes after the last one of a frame
        send_byte(8'hAA, 1'b0, KIND_DATA);
        send_byte(8'h5A, 1'b0, KIND_CONF);
        wait_drained();
    endtask

    // Mostly complete frames with random content and faults, some truncated, the rest noise
    task automatic test_random_stream();
        int target;
        int r;
        int n;
        logic kd;
        target = folded_bytes + RANDOM_BYTES;
        while (folded_bytes < target)
        begin
            // Change the traffic shape now and then
            if ($urandom_range(0, 19) == 0)
            begin
                idle_on  = 1'($urandom_range(0, 3) != 0);
                rdy_mode = rdy_mode_t'($urandom_range(0, 2));
            end
            r  = $urandom_range(0, 99);
            kd = 1'($urandom);
            if (r < 72)
            begin
                send_frame(kd, pick_flaw(), FILL_RANDOM, 16);
            end
            else if (r < 82)
            begin
                n = (kd == KIND_CONF) ? 6 : 15;
                send_frame(kd, pick_flaw(), FILL_RANDOM, $urandom_range(1, n));
            end
            else if (r < 90)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            else
            begin
                n = $urandom_range(4, 20);
                repeat (n)
                    send_byte(8'($urandom), 1'($urandom_range(0, 7) == 0), 1'($urandom));
            end
        end
        wait_drained();
    endtask

    // Hold the output off long enough that the input backs up, then config frames under random stalls
    task automatic test_output_backpressure();
        idle_on   = 1'b0;
        rdy_mode  = RDY_ALWAYS;
        hold_left = 400;
        repeat (6)
            send_frame(1'($urandom), pick_flaw(), FILL_RANDOM, 16);
        wait_drained();
        rdy_mode = RDY_COIN;
        idle_on  = 1'b1;
        repeat (10)
            send_frame(KIND_CONF, pick_flaw(), FILL_RANDOM, 7);
        wait_drained();
    endtask

    // Sequence
    initial
    begin
        rst_n             = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.rx_byte     = 8'h00;
        rx_if.frame_start = 1'b0;
        rx_if.frame_kind  = 1'b0;
        trk_pos           = 4'd0;
        trk_kind          = 1'b0;
        trk_open          = 1'b0;
        trk_hdr_ok        = 1'b1;
        trk_stat_or       = 8'h00;
        trk_sum           = 16'h0000;
        trk_chk_hi        = 8'h00;
        trk_cfg_done      = 1'b0;
        folded_bytes      = 0;
        n_bad             = 0;
        n_shown           = 0;
        burst_left        = 0;
        idle_on           = 1'b0;
        stat_pick         = 1'b0;
        hold_left         = 0;
        rdy_mode          = RDY_ALWAYS;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_frames();
        test_random_stream();
        test_output_backpressure();

        // Let any stray late verdict show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_bad == 0 && verdict_q.size() == 0)
            $display("** sensor_frame_validator: PASSED **");
        else
            $display("** sensor_frame_validator: FAILED **");
        $finish;
    end

endmodule
